@@ design/plic_pkg.sv @@
// ----------------------------------------------------------------------------
// plic_pkg
// Shared types and register map constants of the interrupt controller.
// ----------------------------------------------------------------------------
package plic_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RAISE = 2'd2,
        OP_EVAL  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    localparam logic [25:0] PEND_BASE   = 26'h1000;
    localparam logic [25:0] ENAB_BASE   = 26'h2000;
    localparam logic [25:0] ENAB_STRIDE = 26'h80;
    localparam logic [13:0] CTX_PAGE    = 14'h200;
    localparam logic [11:0] PAGE_OFFS   = 12'hFFF;
    localparam int          WORD_BITS   = 32;
    localparam logic [3:0]  ACCESS_WORD = 4'd4;

endpackage

@@ design/platform_interrupt_controller_core.sv @@
// ----------------------------------------------------------------------------
// platform_interrupt_controller_core
// Platform-level interrupt controller with bus register access, source raise
// and per-context evaluation.
// ----------------------------------------------------------------------------
// Every item yields one result item. An evaluation for a valid context walks
// the sources through one shared priority comparator, one source per cycle.
// Priorities sit in a memory with a registered read port that the scan and
// bus reads share; a written flag per source makes a never-written priority
// read as zero after reset. The pending, enable and claimed bitmaps are
// flip-flops. The input is stalled while an item is at work or its result
// has not been taken.
module platform_interrupt_controller_core #(
    parameter int NUM_SOURCES  = 64,
    parameter int NUM_CONTEXTS = 2,
    parameter int WINDOW_BYTES = 67108864
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [25:0] address,
    input  logic [31:0] write_data,
    input  logic [3:0]  access_bytes,
    input  logic [5:0]  source,
    input  logic        context_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        bus_fault,
    output logic        raise_rejected,
    output logic        interrupt_line,
    output logic [5:0]  selected_source
);

    localparam int SW = $clog2(NUM_SOURCES);
    localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int NW = (NUM_SOURCES + plic_pkg::WORD_BITS - 1) / plic_pkg::WORD_BITS;
    localparam int WW = (NW > 1) ? $clog2(NW) : 1;

    // priority memory
    logic [31:0] prio_mem [NUM_SOURCES];
    logic [31:0] prio_rd_reg;
    logic [NUM_SOURCES-1:0] prio_vld_reg;
    logic        prio_hit_reg;
    logic [31:0] prio_q;

    logic [NUM_SOURCES-1:0] pend_reg;
    logic [NUM_SOURCES-1:0] enab_reg  [NUM_CONTEXTS];
    logic [NUM_SOURCES-1:0] claim_reg [NUM_CONTEXTS];
    logic [31:0]            thr_reg   [NUM_CONTEXTS];
    logic [31:0]            cval_reg  [NUM_CONTEXTS];

    plic_pkg::state_t state_reg, state_next;

    // latched item
    logic [1:0]  op_reg;
    logic [25:0] addr_reg;
    logic [31:0] wd_reg;
    logic [3:0]  size_reg;
    logic [5:0]  src_reg;
    logic [CW-1:0] ctx_reg;
    logic        ctx_ok_reg;

    logic [SW:0]   scan_reg;     // source being read from memory
    logic [SW-1:0] cmp_idx_reg;  // source whose priority is in prio_rd_reg
    logic          cmp_vld_reg;
    logic [31:0]   high_reg;
    logic [SW-1:0] best_reg;

    logic [31:0] rd_reg;
    logic        fault_reg, rej_reg, line_reg;
    logic [5:0]  sel_reg;
    logic        out_vld_reg;

    // ---------------- address decode of the latched item ----------------
    logic        is_prio, is_pend, is_enab, is_ctx, bad_access;
    logic [SW-1:0] prio_idx;
    logic [WW-1:0] word_idx;
    logic [CW-1:0] dec_ctx;
    logic [25:0]   enab_off;
    logic [11:0]   page_low;
    logic [13:0]   page;

    always_comb
    begin
        bad_access = ({6'd0, addr_reg} >= 32'(WINDOW_BYTES))
                     || (size_reg != plic_pkg::ACCESS_WORD);
        page       = addr_reg[25:12];
        page_low   = addr_reg[11:0] & plic_pkg::PAGE_OFFS;
        enab_off   = addr_reg - plic_pkg::ENAB_BASE;
        is_prio    = {6'd0, addr_reg} < 32'(NUM_SOURCES * 4);
        prio_idx   = addr_reg[SW+1:2];
        is_pend    = !is_prio && addr_reg >= plic_pkg::PEND_BASE
                     && {6'd0, addr_reg} < 32'(32'h1000 + NUM_SOURCES / 8);
        is_enab    = !is_prio && !is_pend && addr_reg >= plic_pkg::ENAB_BASE
                     && {6'd0, addr_reg} < 32'(32'h2000 + 32'h80 * NUM_CONTEXTS)
                     && {25'd0, enab_off[6:0]} < 32'(NUM_SOURCES / 8);
        is_ctx     = !is_prio && !is_pend && !(addr_reg >= plic_pkg::ENAB_BASE
                     && {6'd0, addr_reg} < 32'(32'h2000 + 32'h80 * NUM_CONTEXTS))
                     && page >= plic_pkg::CTX_PAGE
                     && {18'd0, page} < 32'(32'h200 + NUM_CONTEXTS);
        if (is_enab)
            dec_ctx = CW'(enab_off[25:7]);
        else
            dec_ctx = CW'(page - plic_pkg::CTX_PAGE);
        if (is_pend)
            word_idx = WW'(addr_reg[11:2]);
        else
            word_idx = WW'(enab_off[6:2]);
    end

    function automatic logic [31:0] word_of(input logic [NUM_SOURCES-1:0] v,
                                            input logic [WW-1:0] w);
        logic [NW*32-1:0] ext;
        ext = (NW*32)'(v);
        return ext[w*32 +: 32];
    endfunction

    // ---------------- sequencer ----------------
    logic start, op_done, scan_last;
    assign start    = in_valid && !in_stall;
    assign in_stall = (state_reg != plic_pkg::ST_IDLE) || out_vld_reg;
    assign scan_last = cmp_vld_reg && (32'(cmp_idx_reg) == 32'(NUM_SOURCES - 1));
    // bus and raise items leave the scan state in the cycle after the memory read is issued
    assign op_done  = (plic_pkg::op_t'(op_reg) != plic_pkg::OP_EVAL)
                      ? (scan_reg != '0) : (scan_last || !ctx_ok_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= plic_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plic_pkg::ST_IDLE: if (start) state_next = plic_pkg::ST_SCAN;
            plic_pkg::ST_SCAN: if (op_done) state_next = plic_pkg::ST_DONE;
            plic_pkg::ST_DONE: state_next = plic_pkg::ST_IDLE;
            default:           state_next = plic_pkg::ST_IDLE;
        endcase
    end

    // memory read address: scan index for evaluation, decoded index for bus
    logic [SW-1:0] mem_raddr;
    logic          scanning;
    logic          prio_wr;
    assign scanning  = (state_reg == plic_pkg::ST_SCAN)
                       && (plic_pkg::op_t'(op_reg) == plic_pkg::OP_EVAL)
                       && (32'(scan_reg) < 32'(NUM_SOURCES));
    assign mem_raddr = (plic_pkg::op_t'(op_reg) == plic_pkg::OP_EVAL)
                       ? scan_reg[SW-1:0] : prio_idx;
    assign prio_wr   = state_reg == plic_pkg::ST_DONE && !bad_access && is_prio
                       && plic_pkg::op_t'(op_reg) == plic_pkg::OP_WRITE
                       && prio_idx != '0;

    always_ff @(posedge clk)
    begin
        prio_rd_reg  <= prio_mem[mem_raddr];
        prio_hit_reg <= prio_vld_reg[mem_raddr];
        if (prio_wr)
            prio_mem[prio_idx] <= wd_reg;
    end

    // a priority that was never written reads as zero
    assign prio_q = prio_hit_reg ? prio_rd_reg : '0;

    // ---------------- datapath ----------------
    logic cur_claimed, cur_cand;
    always_comb
    begin
        cur_claimed = claim_reg[ctx_reg][cmp_idx_reg];
        cur_cand    = !cur_claimed && enab_reg[ctx_reg][cmp_idx_reg]
                      && pend_reg[cmp_idx_reg]
                      && prio_q >= high_reg && prio_q >= thr_reg[ctx_reg];
    end

    logic        bus_op, wr_op;
    logic [31:0] cv;
    logic [NUM_SOURCES-1:0] claimed_any;
    logic [SW-1:0] cv_idx, wd_idx, rs_idx;
    always_comb
    begin
        bus_op = (plic_pkg::op_t'(op_reg) == plic_pkg::OP_READ)
                 || (plic_pkg::op_t'(op_reg) == plic_pkg::OP_WRITE);
        wr_op  = plic_pkg::op_t'(op_reg) == plic_pkg::OP_WRITE;
        cv     = cval_reg[dec_ctx];
        cv_idx = cv[SW-1:0];
        wd_idx = wd_reg[SW-1:0];
        rs_idx = SW'(src_reg);
        claimed_any = '0;
        for (int c = 0; c < NUM_CONTEXTS; c++)
            claimed_any = claimed_any | claim_reg[c];
    end

    // word returned by a bus read
    logic [31:0] rd_word;
    logic        eval_ok;
    always_comb
    begin
        rd_word = '0;
        eval_ok = (plic_pkg::op_t'(op_reg) == plic_pkg::OP_EVAL) && ctx_ok_reg;
        if (bus_op && !bad_access && !wr_op)
        begin
            priority if (is_prio)
                rd_word = prio_q;
            else if (is_pend)
                rd_word = word_of(pend_reg, word_idx);
            else if (is_enab)
                rd_word = word_of(enab_reg[dec_ctx], word_idx);
            else if (is_ctx && page_low == 12'd0)
                rd_word = thr_reg[dec_ctx];
            else if (is_ctx && page_low == 12'd4)
                rd_word = cv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '0;
            prio_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
            scan_reg     <= '0;
            cmp_vld_reg  <= 1'b0;
            for (int c = 0; c < NUM_CONTEXTS; c++)
            begin
                enab_reg[c]  <= '0;
                claim_reg[c] <= '0;
                thr_reg[c]   <= '0;
                cval_reg[c]  <= '0;
            end
        end
        else
        begin
            if (out_vld_reg && !out_stall)
                out_vld_reg <= 1'b0;
            if (prio_wr)
                prio_vld_reg[prio_idx] <= 1'b1;
            if (start)
            begin
                scan_reg    <= '0;
                cmp_vld_reg <= 1'b0;
            end
            if (state_reg == plic_pkg::ST_SCAN)
            begin
                // advance the scan; one source reaches the comparator each cycle
                if (32'(scan_reg) < 32'(NUM_SOURCES))
                    scan_reg <= scan_reg + 1'b1;
                cmp_vld_reg <= scanning;
                if (cmp_vld_reg && plic_pkg::op_t'(op_reg) == plic_pkg::OP_EVAL
                    && cur_claimed)
                    pend_reg[cmp_idx_reg] <= 1'b0;
            end
            if (state_reg == plic_pkg::ST_DONE)
            begin
                out_vld_reg <= 1'b1;
                if (plic_pkg::op_t'(op_reg) == plic_pkg::OP_EVAL && ctx_ok_reg)
                    cval_reg[ctx_reg] <= 32'(best_reg);
                if (plic_pkg::op_t'(op_reg) == plic_pkg::OP_RAISE && !rej_reg)
                    pend_reg[rs_idx] <= 1'b1;
                if (bus_op && !bad_access)
                begin
                    if (wr_op && is_pend)
                        for (int s = 1; s < NUM_SOURCES; s++)
                            if (WW'(s / 32) == word_idx)
                                pend_reg[s] <= wd_reg[s % 32];
                    if (wr_op && is_enab)
                        for (int s = 1; s < NUM_SOURCES; s++)
                            if (WW'(s / 32) == word_idx)
                                enab_reg[dec_ctx][s] <= wd_reg[s % 32];
                    if (is_ctx && page_low == 12'd0 && wr_op)
                        thr_reg[dec_ctx] <= wd_reg;
                    if (is_ctx && page_low == 12'd4)
                    begin
                        if (wr_op)
                        begin
                            cval_reg[dec_ctx] <= wd_reg;
                            if (wd_reg < 32'(NUM_SOURCES))
                                claim_reg[dec_ctx][wd_idx] <= 1'b0;
                        end
                        else if (cv < 32'(NUM_SOURCES) && pend_reg[cv_idx])
                            claim_reg[dec_ctx][cv_idx] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg     <= operation;
            addr_reg   <= address;
            wd_reg     <= write_data;
            size_reg   <= access_bytes;
            src_reg    <= source;
            ctx_reg    <= CW'(context_req);
            ctx_ok_reg <= 32'(context_req) < 32'(NUM_CONTEXTS);
            high_reg   <= '0;
            best_reg   <= '0;
        end
        cmp_idx_reg <= scan_reg[SW-1:0];
        if (state_reg == plic_pkg::ST_SCAN && cmp_vld_reg && cur_cand)
        begin
            high_reg <= prio_q;
            best_reg <= cmp_idx_reg;
        end
        // raise check is settled in the scan state, ahead of the result
        if (state_reg == plic_pkg::ST_SCAN)
            rej_reg <= (src_reg == 6'd0) || (32'(src_reg) >= 32'(NUM_SOURCES))
                       || pend_reg[rs_idx] || claimed_any[rs_idx];
        if (state_reg == plic_pkg::ST_DONE)
        begin
            rd_reg    <= rd_word;
            fault_reg <= bus_op && bad_access;
            // hold the raise verdict; drop it for every other item
            if (plic_pkg::op_t'(op_reg) != plic_pkg::OP_RAISE)
                rej_reg <= 1'b0;
            line_reg  <= eval_ok && (best_reg != '0);
            sel_reg   <= eval_ok ? 6'(best_reg) : 6'd0;
        end
    end

    assign out_valid       = out_vld_reg;
    assign read_data       = rd_reg;
    assign bus_fault       = fault_reg;
    assign raise_rejected  = rej_reg;
    assign interrupt_line  = line_reg;
    assign selected_source = sel_reg;

    // ---------------- assertions ----------------
    a_line_sel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (interrupt_line == (selected_source != 6'd0)))
        else $error("line disagrees with selection");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != plic_pkg::ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_src0: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg[0])
        else $error("source zero pending");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == plic_pkg::ST_DONE))
        else $error("result without finished item");

endmodule
